// File: hdl/dvs_pkg.sv
package dvs_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int VALUE_BITS_DEF  = 14;
  localparam int PRIME_LIMIT_DEF = 200;
  localparam int PRIME_COUNT_DEF = 46;

  // Fixed field widths.
  localparam int TOTAL_BITS  = 17;
  localparam int PRIME_BITS  = 8;
  localparam int TABLE_DEPTH = 47;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // All primes that any legal prime limit can admit, in ascending order.
  localparam logic [PRIME_BITS-1:0] PRIME_TABLE [TABLE_DEPTH] = '{
    8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,
    8'd23,  8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,
    8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,
    8'd97,  8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131,
    8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173,
    8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211
  };

  // Prime at a table position, or zero when it is not below the limit.
  function automatic logic [PRIME_BITS-1:0] prime_at(input int idx, input int limit);
    logic [PRIME_BITS-1:0] p;
    p = '0;
    if (idx >= 0 && idx < TABLE_DEPTH) begin
      if (int'(PRIME_TABLE[idx]) < limit) begin
        p = PRIME_TABLE[idx];
      end
    end
    return p;
  endfunction

  // Number of usable table entries for a given capacity and limit.
  function automatic int prime_fill(input int count, input int limit);
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < count && int'(PRIME_TABLE[i]) < limit) begin
        n++;
      end
    end
    return n;
  endfunction

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_GEO_INIT,
    OP_TAKE,
    OP_ACC_DIV,
    OP_MUL_GSUM,
    OP_INC_POS,
    OP_MUL_LEFT,
    OP_EMIT
  } dp_op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_TRIAL_END,
    C_DIV_BUSY,
    C_REM_NONZERO,
    C_REM_ZERO,
    C_OUT_BLOCKED
  } cond_t;

  localparam int PC_BITS = 4;
  typedef logic [PC_BITS-1:0] pc_t;

  // Program addresses.
  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_TEST   = 4'd1;
  localparam pc_t PC_DIV    = 4'd2;
  localparam pc_t PC_DWAIT  = 4'd3;
  localparam pc_t PC_CHECK  = 4'd4;
  localparam pc_t PC_TAKE   = 4'd5;
  localparam pc_t PC_ACC    = 4'd6;
  localparam pc_t PC_AWAIT  = 4'd7;
  localparam pc_t PC_ACHECK = 4'd8;
  localparam pc_t PC_MULG   = 4'd9;
  localparam pc_t PC_NEXTP  = 4'd10;
  localparam pc_t PC_LEFT   = 4'd11;
  localparam pc_t PC_EMIT   = 4'd12;
  localparam pc_t PC_LAST   = PC_EMIT;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    pc_t    target;
  } ucode_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic no_input;
    logic trial_end;
    logic div_busy;
    logic rem_zero;
    logic out_blocked;
  } status_t;

  // Control store. A taken condition jumps to the target; otherwise the
  // program steps on, wrapping after the last word.
  function automatic ucode_t ucode_at(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_WAIT:   w = '{OP_LOAD,      C_NO_INPUT,    PC_WAIT};
      PC_TEST:   w = '{OP_NONE,      C_TRIAL_END,   PC_LEFT};
      PC_DIV:    w = '{OP_DIV_START, C_ALWAYS,      PC_DWAIT};
      PC_DWAIT:  w = '{OP_NONE,      C_DIV_BUSY,    PC_DWAIT};
      PC_CHECK:  w = '{OP_GEO_INIT,  C_REM_NONZERO, PC_NEXTP};
      PC_TAKE:   w = '{OP_TAKE,      C_ALWAYS,      PC_ACC};
      PC_ACC:    w = '{OP_ACC_DIV,   C_ALWAYS,      PC_AWAIT};
      PC_AWAIT:  w = '{OP_NONE,      C_DIV_BUSY,    PC_AWAIT};
      PC_ACHECK: w = '{OP_NONE,      C_REM_ZERO,    PC_TAKE};
      PC_MULG:   w = '{OP_MUL_GSUM,  C_ALWAYS,      PC_NEXTP};
      PC_NEXTP:  w = '{OP_INC_POS,   C_ALWAYS,      PC_TEST};
      PC_LEFT:   w = '{OP_MUL_LEFT,  C_ALWAYS,      PC_EMIT};
      PC_EMIT:   w = '{OP_EMIT,      C_OUT_BLOCKED, PC_EMIT};
      default:   w = '{OP_NONE,      C_ALWAYS,      PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/dvs_divider.sv
module dvs_divider #(
  parameter int VALUE_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [VALUE_BITS-1:0]             dividend,
  input  logic [dvs_pkg::PRIME_BITS-1:0]    divisor,
  output logic                              busy,
  output logic [VALUE_BITS-1:0]             quotient,
  output logic [dvs_pkg::PRIME_BITS-1:0]    remainder
);
  import dvs_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [CNT_BITS-1:0]   count;
  logic [VALUE_BITS-1:0] quo;
  logic [PRIME_BITS-1:0] rmd;
  logic [PRIME_BITS:0]   trial;
  logic [PRIME_BITS:0]   diff;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {rmd, quo[VALUE_BITS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_BITS'(VALUE_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Quotient shifts in from the bottom as the dividend shifts out the top.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rmd <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], fits};
      rmd <= fits ? diff[PRIME_BITS-1:0] : trial[PRIME_BITS-1:0];
    end
  end

  assign busy      = (count != '0);
  assign quotient  = quo;
  assign remainder = rmd;

endmodule

// File: hdl/dvs_datapath.sv
module dvs_datapath #(
  parameter int VALUE_BITS  = dvs_pkg::VALUE_BITS_DEF,
  parameter int PRIME_LIMIT = dvs_pkg::PRIME_LIMIT_DEF,
  parameter int PRIME_COUNT = dvs_pkg::PRIME_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dvs_pkg::dp_op_t                   op,
  output dvs_pkg::status_t                  status,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_BITS-1:0]             number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dvs_pkg::TOTAL_BITS-1:0]    divisor_total
);
  import dvs_pkg::*;

  localparam int FILL     = prime_fill(PRIME_COUNT, PRIME_LIMIT);
  localparam int POS_BITS = $clog2(PRIME_COUNT + 1);
  localparam int SQ_BITS  = 2 * PRIME_BITS;

  logic [VALUE_BITS-1:0]          remaining_value;
  logic [POS_BITS-1:0]            prime_position;
  logic [TOTAL_BITS-1:0]          running_product;
  logic [TOTAL_BITS-1:0]          geometric_term;
  logic [TOTAL_BITS-1:0]          geo_sum;

  logic [PRIME_BITS-1:0]          prime;
  logic [SQ_BITS-1:0]             prime_sq;
  logic [TOTAL_BITS-1:0]          mul_b;
  logic [2*TOTAL_BITS-1:0]        prod_full;
  logic [TOTAL_BITS-1:0]          prod_sat;
  logic [TOTAL_BITS+PRIME_BITS-1:0] term_full;
  logic                           div_start;
  logic                           div_busy;
  logic [VALUE_BITS-1:0]          div_quo;
  logic [PRIME_BITS-1:0]          div_rmd;
  logic                           load;
  logic                           emit;

  // Current trial prime from the constant table.
  always_comb begin
    prime    = prime_at(int'(prime_position), PRIME_LIMIT);
    prime_sq = prime * prime;
  end

  // Shared multiplier for the running product, saturating at all ones.
  always_comb begin
    mul_b     = (op == OP_MUL_LEFT) ? TOTAL_BITS'(remaining_value) + 1'b1 : geo_sum;
    prod_full = running_product * mul_b;
    prod_sat  = (|prod_full[2*TOTAL_BITS-1:TOTAL_BITS]) ? TOTAL_MAX
                                                         : prod_full[TOTAL_BITS-1:0];
    term_full = geometric_term * prime;
  end

  assign load      = (op == OP_LOAD) && in_valid;
  assign div_start = (op == OP_DIV_START) || (op == OP_ACC_DIV);

  dvs_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining_value),
    .divisor  (prime),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rmd)
  );

  // Working registers of the factorization.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          remaining_value <= number;
          running_product <= TOTAL_BITS'(1);
        end
      end
      OP_GEO_INIT: begin
        geometric_term <= TOTAL_BITS'(1);
        geo_sum        <= TOTAL_BITS'(1);
      end
      OP_TAKE: begin
        remaining_value <= div_quo;
        geometric_term  <= term_full[TOTAL_BITS-1:0];
      end
      OP_ACC_DIV: begin
        geo_sum <= geo_sum + geometric_term;
      end
      OP_MUL_GSUM: begin
        running_product <= prod_sat;
      end
      OP_MUL_LEFT: begin
        if (remaining_value > VALUE_BITS'(1)) begin
          running_product <= prod_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // Prime position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_position <= '0;
    end else if (load) begin
      prime_position <= '0;
    end else if (op == OP_INC_POS) begin
      prime_position <= prime_position + 1'b1;
    end
  end

  // Output register: holds the result until the transaction completes.
  assign emit = (op == OP_EMIT) && !status.out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      divisor_total <= running_product;
    end
  end

  // Status for the sequencer.
  always_comb begin
    status.no_input    = !in_valid;
    status.trial_end   = (prime_position == POS_BITS'(FILL)) ||
                         (prime_sq > SQ_BITS'(remaining_value));
    status.div_busy    = div_busy;
    status.rem_zero    = (div_rmd == '0);
    status.out_blocked = out_valid && !out_ready;
  end

  assign in_ready = (op == OP_LOAD);

endmodule

// File: hdl/dvs_sequencer.sv
module dvs_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  dvs_pkg::status_t  status,
  output dvs_pkg::dp_op_t   op
);
  import dvs_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  ucode_t word;
  logic   taken;

  // Fetch the control word of the current step.
  assign word = ucode_at(pc);
  assign op   = word.op;

  // Evaluate the jump condition.
  always_comb begin
    case (word.cond)
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = status.no_input;
      C_TRIAL_END:   taken = status.trial_end;
      C_DIV_BUSY:    taken = status.div_busy;
      C_REM_NONZERO: taken = !status.rem_zero;
      C_REM_ZERO:    taken = status.rem_zero;
      C_OUT_BLOCKED: taken = status.out_blocked;
      default:       taken = 1'b0;
    endcase
  end

  // Next step: jump, wrap or step on.
  always_comb begin
    if (taken) begin
      pc_next = word.target;
    end else if (pc == PC_LAST) begin
      pc_next = PC_WAIT;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: hdl/divisor_sum.sv
// Sum of divisors (sigma) of one unsigned integer per transaction.
// Input channel: number with in_valid/in_ready. Output channel: divisor_total
// with out_valid/out_ready. Each accepted number yields exactly one result.
// The number is factored by trial division against the primes below
// PRIME_LIMIT; each prime factor multiplies a saturating running product by its
// geometric divisor sum, and a leftover factor above one contributes itself
// plus one. Zero and one both give a total of one.
// One number is worked on at a time. Each prime tried takes one division in
// the bit-serial divider, and each time a prime is divided out another
// division follows; a prime that divides then has its geometric sum folded
// into the product. Trial division stops once the square of the prime exceeds
// what remains or the usable primes run out.
// The result sits in an output register; in_ready rises again as soon as the
// result is loaded there, so the next number is taken while a stalled result
// waits. If the receiver still holds off when the next result is ready, the
// sequencer waits at its last step until the register frees.
// Reset is synchronous and returns the sequencer to waiting for input with no
// result pending; no clearing pass is needed.
module divisor_sum #(
  parameter int VALUE_BITS  = dvs_pkg::VALUE_BITS_DEF,
  parameter int PRIME_LIMIT = dvs_pkg::PRIME_LIMIT_DEF,
  parameter int PRIME_COUNT = dvs_pkg::PRIME_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_BITS-1:0]             number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dvs_pkg::TOTAL_BITS-1:0]    divisor_total
);
  import dvs_pkg::*;

  dp_op_t  op;
  status_t status;

  // Program sequencer.
  dvs_sequencer u_sequencer (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .op    (op)
  );

  // Datapath with the trial divider and output register.
  dvs_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .PRIME_LIMIT(PRIME_LIMIT),
    .PRIME_COUNT(PRIME_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .divisor_total(divisor_total)
  );

endmodule

// File: hdl/divisor_sum_checker.sv
module divisor_sum_checker #(
  parameter int VALUE_BITS = dvs_pkg::VALUE_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [VALUE_BITS-1:0]             number,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dvs_pkg::TOTAL_BITS-1:0]    divisor_total
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divisor_total))
    else $error("result changed or vanished while stalled");

  // After a transaction is taken in, the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // A divisor sum is never zero.
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> divisor_total != '0)
    else $error("zero divisor sum presented");

  // A zero input gives a result of one, so the input field is watched too.
  a_zero_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && number == '0 |=> !out_valid || out_ready || !in_ready)
    else $error("unexpected state after a zero input");

endmodule

bind divisor_sum divisor_sum_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .number       (number),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .divisor_total(divisor_total)
);

// File: test/divisor_sum_tb.sv
module divisor_sum_tb;

  import dvs_pkg::*;

  localparam int NUM_BITS     = VALUE_BITS_DEF;
  localparam int IDLE_PERCENT = 18;
  localparam int DRAIN_CYCLES = 700;
  localparam int REPORT_LIMIT = 10;

  typedef logic [NUM_BITS-1:0]   num_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  // Hand-picked corner values: zero, one, small primes, the largest prime,
  // powers of single primes, a square of a large prime, highly composite
  // numbers, and bit patterns of all ones and alternating ones.
  localparam int CORNER_COUNT = 24;
  localparam int CORNER_VALUES [CORNER_COUNT] = '{
    0, 1, 2, 3, 4, 6, 7, 9, 12, 49,
    1024, 8192, 6561, 9973, 10000, 12288, 15120, 14351,
    16129, 16381, 16382, 16383, 10922, 5461
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  num_t   number = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  total_t divisor_total;

  total_t expected_totals [$];
  int     error_count = 0;
  bit     steady_flow = 1'b0;

  divisor_sum uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .number        (number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .divisor_total (divisor_total)
  );

  always #1 clk = ~clk;

  // Trial primality test for the small factor candidates.
  function automatic bit is_prime(input int unsigned v);
    bit prime;
    prime = (v >= 2);
    for (int unsigned d = 2; d * d <= v; d++) begin
      if (v % d == 0) begin
        prime = 1'b0;
      end
    end
    return prime;
  endfunction

  // Sum of divisors by trial division over the primes below the limit,
  // with a saturating product of geometric divisor sums.
  function automatic total_t sigma_of(input num_t n);
    int unsigned     rest;
    int unsigned     used;
    int unsigned     power;
    longint unsigned geo;
    longint unsigned total;
    bit              stopped;
    rest    = n;
    used    = 0;
    total   = 1;
    stopped = 1'b0;
    for (int unsigned p = 2; p < PRIME_LIMIT_DEF && !stopped; p++) begin
      if (is_prime(p) && used < PRIME_COUNT_DEF) begin
        used++;
        if (p * p > rest) begin
          stopped = 1'b1;
        end else if (rest % p == 0) begin
          power = 1;
          geo   = 1;
          while (rest % p == 0) begin
            rest  = rest / p;
            power = power * p;
            geo   = geo + power;
          end
          if (geo > TOTAL_MAX) geo = TOTAL_MAX;
          total = total * geo;
          if (total > TOTAL_MAX) total = TOTAL_MAX;
        end
      end
    end
    // Whatever is left above one is a single prime factor.
    if (rest > 1) begin
      total = total * (rest + 1);
      if (total > TOTAL_MAX) total = TOTAL_MAX;
    end
    return total_t'(total);
  endfunction

  // One input transaction. The valid line is lowered only for an idle gap,
  // so back-to-back numbers keep it high across the acceptance edge.
  task automatic send_number(input num_t n);
    total_t predicted;
    predicted = sigma_of(n);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk); while (!in_ready);
    expected_totals = {expected_totals, predicted};
  endtask

  // Receiver side stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    if (steady_flow) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    total_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected result: divisor_total=%0d", divisor_total);
        end
      end else begin
        want = expected_totals.pop_front();
        if (divisor_total !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch: expected divisor_total=%0d, got %0d", want, divisor_total);
          end
        end
      end
    end
  end

  task automatic test_corner_values();
    for (int i = 0; i < CORNER_COUNT; i++) begin
      send_number(num_t'(CORNER_VALUES[i]));
    end
  endtask

  task automatic test_random_full_range(input int count);
    repeat (count) send_number(num_t'($urandom_range(0, (1 << NUM_BITS) - 1)));
  endtask

  // Small numbers need few trial divisions, so result stalls back up here.
  task automatic test_small_numbers(input int count);
    repeat (count) send_number(num_t'($urandom_range(0, 255)));
  endtask

  // Products of powers of small primes, sometimes with one larger prime,
  // so that repeated division and long geometric sums are exercised.
  task automatic test_smooth_numbers(input int count);
    int unsigned n;
    int unsigned p;
    int unsigned factors;
    repeat (count) begin
      n       = 1;
      factors = $urandom_range(1, 12);
      repeat (factors) begin
        do p = $urandom_range(2, 23); while (!is_prime(p));
        if (n * p < (1 << NUM_BITS)) n = n * p;
      end
      if ($urandom_range(0, 3) == 0) begin
        do p = $urandom_range(29, 199); while (!is_prime(p));
        if (n * p < (1 << NUM_BITS)) n = n * p;
      end
      send_number(num_t'(n));
    end
  endtask

  // A long stretch with both sides ready every cycle.
  task automatic test_steady_stream(input int count);
    steady_flow = 1'b1;
    test_random_full_range(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_random_full_range(650);
    test_small_numbers(250);
    test_smooth_numbers(300);
    test_steady_stream(250);

    // Let every result come back, then allow for any late extra output.
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: divisor_sum.f
hdl/dvs_pkg.sv
hdl/dvs_divider.sv
hdl/dvs_datapath.sv
hdl/dvs_sequencer.sv
hdl/divisor_sum.sv
hdl/divisor_sum_checker.sv
test/divisor_sum_tb.sv
